FILE: rtl/erle_pkg.sv
// Types and constants shared by the escape run-length decoder files.
`timescale 1ns / 1ps

package erle_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 9;
  localparam int unsigned LimitW = 16;

  // Decoder phase codes.
  localparam logic [1:0] PH_IDLE       = 2'd0;
  localparam logic [1:0] PH_NORMAL     = 2'd1;
  localparam logic [1:0] PH_AFTER_ESC  = 2'd2;
  localparam logic [1:0] PH_HAVE_VALUE = 2'd3;

  // A count byte of zero stands for a full run of 256.
  localparam logic [CountW-1:0] FULL_RUN = 9'd256;

  localparam logic [LimitW-1:0] LIMIT_RESET = 16'hFFFF;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             stream_start;
    logic             last_in;
  } in_item_t;

  typedef struct packed {
    logic [ByteW-1:0]  out_value;
    logic [CountW-1:0] repeat_count;
    logic              limit_reached;
  } out_item_t;

  // Beat handed from the input register to the decoding stage.
  typedef struct packed {
    logic     process;
    in_item_t item;
  } step_t;

  // Outcome of one decoding step.
  typedef struct packed {
    logic      emit;
    out_item_t run;
  } run_res_t;

endpackage

FILE: rtl/erle_if.sv
// Valid/ready stream interface carrying one payload beat.
`timescale 1ns / 1ps

interface erle_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/erle_core.sv
// Decoder state and the single-step decoding logic for one compressed byte.
`timescale 1ns / 1ps

module erle_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  erle_pkg::step_t               step_i,
  input  logic [erle_pkg::LimitW-1:0]   limit_i,
  output erle_pkg::run_res_t            result_o
);

  logic [erle_pkg::ByteW-1:0]  esc_q, esc_d;
  logic [1:0]                  phase_q, phase_d;
  logic [erle_pkg::ByteW-1:0]  held_q, held_d;
  logic [erle_pkg::LimitW-1:0] produced_q, produced_d;

  logic [erle_pkg::ByteW-1:0]  b;
  logic                        want;
  logic [erle_pkg::ByteW-1:0]  want_value;
  logic [erle_pkg::CountW-1:0] want_count;
  logic [erle_pkg::LimitW-1:0] room;
  logic [erle_pkg::CountW-1:0] clip_count;
  logic [erle_pkg::LimitW-1:0] produced_new;
  logic                        below_limit;

  assign b           = step_i.item.data_byte;
  assign below_limit = produced_q < limit_i;
  assign room        = limit_i - produced_q;

  // Clip the requested run to the room left below the limit.
  always_comb begin
    if ({7'd0, want_count} > room) begin
      clip_count = room[erle_pkg::CountW-1:0];
    end else begin
      clip_count = want_count;
    end
  end

  assign produced_new = produced_q + {7'd0, clip_count};

  always_comb begin
    esc_d      = esc_q;
    phase_d    = phase_q;
    held_d     = held_q;
    produced_d = produced_q;
    want       = 1'b0;
    want_value = b;
    want_count = 9'd1;
    if (step_i.process) begin
      if (step_i.item.stream_start) begin
        esc_d      = b;
        produced_d = '0;
        held_d     = '0;
        phase_d    = step_i.item.last_in ? erle_pkg::PH_IDLE : erle_pkg::PH_NORMAL;
      end else if (phase_q != erle_pkg::PH_IDLE) begin
        if (below_limit) begin
          unique case (phase_q)
            erle_pkg::PH_NORMAL: begin
              if (b != esc_q) begin
                want = 1'b1;
              end else begin
                phase_d = erle_pkg::PH_AFTER_ESC;
              end
            end
            erle_pkg::PH_AFTER_ESC: begin
              if (b == esc_q) begin
                want    = 1'b1;
                phase_d = erle_pkg::PH_NORMAL;
              end else begin
                held_d  = b;
                phase_d = erle_pkg::PH_HAVE_VALUE;
              end
            end
            erle_pkg::PH_HAVE_VALUE: begin
              want       = 1'b1;
              want_value = held_q;
              want_count = (b == '0) ? erle_pkg::FULL_RUN : {1'b0, b};
              phase_d    = erle_pkg::PH_NORMAL;
            end
            default: begin
              phase_d = phase_q;
            end
          endcase
          if (want) begin
            produced_d = produced_new;
          end
        end
        if (step_i.item.last_in) begin
          phase_d = erle_pkg::PH_IDLE;
        end
      end
    end
  end

  always_comb begin
    result_o.emit              = want;
    result_o.run.out_value     = want_value;
    result_o.run.repeat_count  = clip_count;
    result_o.run.limit_reached = produced_new >= limit_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q      <= '0;
      phase_q    <= erle_pkg::PH_IDLE;
      held_q     <= '0;
      produced_q <= '0;
    end else begin
      esc_q      <= esc_d;
      phase_q    <= phase_d;
      held_q     <= held_d;
      produced_q <= produced_d;
    end
  end

  // A run is only produced for a processed byte while a stream is open.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.emit |-> (step_i.process && !step_i.item.stream_start &&
                       phase_q != erle_pkg::PH_IDLE))
    else $error("run emitted outside an open stream");

  // A stream start always clears the produced count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i.process && step_i.item.stream_start) |=> produced_q == '0)
    else $error("produced count not cleared on stream start");

  // An emitted run never overshoots the limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.emit |-> (produced_new <= limit_i && produced_new > produced_q))
    else $error("run overshoots output limit");

endmodule

FILE: rtl/escape_rle_decoder.sv
// Top level of the escape-byte run-length decoder: handshake, limit register, input and output registers.
`timescale 1ns / 1ps

// The decoder takes one compressed byte per cycle and hands out at most one run
// descriptor (value, repeat count 1 to 256, limit flag) per byte. A byte passes
// through an input register, the combinational decoding logic and a result
// register that drives the output. Input ready falls only when both registers
// hold a beat and the sink is stalling; with the sink ready the block sustains
// one byte every cycle. The output limit should be written only while no bytes
// are in flight.
module escape_rle_decoder (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [erle_pkg::LimitW-1:0]  cfg_wdata_i,
  erle_if.sink                         in_i,
  erle_if.source                       out_o
);

  logic [erle_pkg::LimitW-1:0] limit_q;

  logic                 in_vld_q, in_vld_d;
  erle_pkg::in_item_t   in_item_q;
  logic                 out_vld_q, out_vld_d;
  erle_pkg::out_item_t  out_item_q;

  logic                 advance;
  logic                 in_ready;
  erle_pkg::step_t      step;
  erle_pkg::run_res_t   res;

  assign advance  = !out_vld_q || out_o.ready;
  assign in_ready = !in_vld_q || advance;

  assign step.process = in_vld_q && advance;
  assign step.item    = in_item_q;

  erle_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .limit_i  (limit_q),
    .result_o (res)
  );

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_ready) begin
      in_vld_d = in_i.valid;
    end
    out_vld_d = out_vld_q;
    if (advance) begin
      out_vld_d = step.process && res.emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q   <= erle_pkg::LIMIT_RESET;
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      in_item_q <= in_i.payload;
    end
    if (step.process && res.emit) begin
      out_item_q <= res.run;
    end
  end

  assign in_i.ready    = in_ready;
  assign out_o.valid   = out_vld_q;
  assign out_o.payload = out_item_q;

  // Every delivered run carries at least one byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> out_item_q.repeat_count != '0)
    else $error("run descriptor with zero repeat count");

  // Back-pressure reaches the input only when both registers are full and stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> (in_vld_q && out_vld_q && !out_o.ready))
    else $error("input stalled without a full pipeline");

  // A processed byte with no new beat behind it leaves the input register empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step.process && !in_i.valid) |=> !in_vld_q)
    else $error("input beat processed twice");

endmodule
